@@ rtl/core/lbs_pkg.sv @@
// Shared types, constants and saturation helpers for the linear blend skinning block.
package lbs_pkg;

    localparam int DATA_W   = 32;
    localparam int ACC_W    = 48;
    localparam int OPND_W   = 33;
    localparam int PROD_W   = 66;
    localparam int JOINT_W  = 6;
    localparam int ENTRY_W  = 4;
    localparam int WEIGHT_W = 17;
    localparam int ENTRIES  = 12;

    localparam logic CMD_WRITE     = 1'b0;
    localparam logic CMD_INFLUENCE = 1'b1;

    localparam logic [WEIGHT_W-1:0] ONE_Q16   = 17'd65536;
    localparam logic signed [OPND_W-1:0] ONE_OPND = 33'sd65536;
    localparam logic signed [PROD_W-1:0] ROUND_HALF = 66'sd32768;

    localparam logic [2:0] STEP_MUL0  = 3'd0;
    localparam logic [2:0] STEP_MUL1  = 3'd1;
    localparam logic [2:0] STEP_MUL2  = 3'd2;
    localparam logic [2:0] STEP_TRANS = 3'd3;
    localparam logic [2:0] STEP_WAIT  = 3'd4;
    localparam logic [2:0] STEP_WLO   = 3'd5;
    localparam logic [2:0] STEP_WHI   = 3'd6;
    localparam logic [2:0] STEP_ACC   = 3'd7;
    localparam logic [1:0] LAST_ROW   = 2'd2;
    localparam logic [1:0] COL_TRANS  = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROW,
        ST_FINAL
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_MUL,
        OP_TRANS,
        OP_WLO,
        OP_WHI,
        OP_ACC,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] row;
        logic [1:0] col;
        logic       first;
    } uop_t;

    typedef struct packed {
        logic               en;
        logic [ENTRY_W-1:0] entry;
    } rd_req_t;

    typedef struct packed {
        logic                    hit;
        logic signed [ACC_W-1:0] value;
    } clamp48_t;

    typedef struct packed {
        logic                     hit;
        logic signed [DATA_W-1:0] value;
    } clamp32_t;

    function automatic clamp48_t clamp48(input logic signed [50:0] v);
        clamp48_t r;
        if (v[50:47] == 4'b0000 || v[50:47] == 4'b1111)
        begin
            r.hit   = 1'b0;
            r.value = v[47:0];
        end
        else
        begin
            r.hit   = 1'b1;
            r.value = v[50] ? {1'b1, {47{1'b0}}} : {1'b0, {47{1'b1}}};
        end
        return r;
    endfunction

    function automatic clamp32_t clamp32(input logic signed [ACC_W-1:0] v);
        clamp32_t r;
        if (v[47:31] == {17{1'b0}} || v[47:31] == {17{1'b1}})
        begin
            r.hit   = 1'b0;
            r.value = v[31:0];
        end
        else
        begin
            r.hit   = 1'b1;
            r.value = v[47] ? {1'b1, {31{1'b0}}} : {1'b0, {31{1'b1}}};
        end
        return r;
    endfunction

endpackage

@@ rtl/core/lbs_table.sv @@
// Joint transform store: one write port, one registered read port.
module lbs_table #(
    parameter int MAX_JOINTS = 64
) (
    input  logic                           clk,
    input  logic                           wr_en,
    input  logic                           cap_en,
    input  logic [lbs_pkg::JOINT_W-1:0]    joint_index,
    input  logic [lbs_pkg::ENTRY_W-1:0]    entry_index,
    input  logic signed [lbs_pkg::DATA_W-1:0] entry_value,
    input  lbs_pkg::rd_req_t               rd,
    output logic signed [lbs_pkg::DATA_W-1:0] rd_data
);
    import lbs_pkg::*;

    localparam int DEPTH = MAX_JOINTS * ENTRIES;
    localparam int AW    = $clog2(DEPTH);

    logic signed [DATA_W-1:0] mem [DEPTH];
    logic signed [DATA_W-1:0] data_reg;
    logic [AW-1:0]            base_reg;
    logic                     oob_reg;
    logic [AW-1:0]            wr_addr;
    logic [AW-1:0]            rd_addr;
    logic                     wr_ok;
    logic                     joint_ok;

    assign joint_ok = 32'(joint_index) < 32'(MAX_JOINTS);
    assign wr_ok    = wr_en && joint_ok && (32'(entry_index) < 32'(ENTRIES));
    assign wr_addr  = AW'(32'(joint_index) * ENTRIES + 32'(entry_index));
    assign rd_addr  = base_reg + AW'(rd.entry);

    always_ff @(posedge clk)
    begin
        if (cap_en)
        begin
            base_reg <= AW'(32'(joint_index) * ENTRIES);
            oob_reg  <= !joint_ok;
        end
        if (wr_ok)
        begin
            mem[wr_addr] <= entry_value;
        end
        if (rd.en && !oob_reg)
        begin
            data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = oob_reg ? '0 : data_reg;

endmodule

@@ rtl/core/lbs_seq.sv @@
// Sequencer that issues the micro-operations of one influence row by row.
module lbs_seq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             command,
    input  logic             last_influence,
    output logic             busy,
    output lbs_pkg::uop_t    uop,
    output lbs_pkg::rd_req_t rd
);
    import lbs_pkg::*;

    state_t     state_reg;
    state_t     state_next;
    logic [2:0] step_reg;
    logic [2:0] step_next;
    logic [1:0] row_reg;
    logic [1:0] row_next;
    logic       last_reg;
    logic       accept;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        row_next   = row_reg;
        case (state_reg)
            ST_IDLE:
            begin
                step_next = STEP_MUL0;
                row_next  = 2'd0;
                if (accept && command == CMD_INFLUENCE)
                begin
                    state_next = ST_ROW;
                end
            end
            ST_ROW:
            begin
                step_next = step_reg + 3'd1;
                if (step_reg == STEP_ACC)
                begin
                    row_next = row_reg + 2'd1;
                    if (row_reg == LAST_ROW)
                    begin
                        state_next = ST_FINAL;
                    end
                end
            end
            ST_FINAL:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        uop.op    = OP_NONE;
        uop.row   = row_reg;
        uop.col   = step_reg[1:0];
        uop.first = (step_reg == STEP_MUL0);
        if (state_reg == ST_ROW)
        begin
            case (step_reg)
                STEP_MUL0, STEP_MUL1, STEP_MUL2: uop.op = OP_MUL;
                STEP_TRANS: uop.op = OP_TRANS;
                STEP_WAIT:  uop.op = OP_NONE;
                STEP_WLO:   uop.op = OP_WLO;
                STEP_WHI:   uop.op = OP_WHI;
                STEP_ACC:   uop.op = OP_ACC;
                default:    uop.op = OP_NONE;
            endcase
        end
        else if (state_reg == ST_FINAL)
        begin
            uop.op = last_reg ? OP_EMIT : OP_NONE;
        end
        rd.en    = (uop.op == OP_MUL) || (uop.op == OP_TRANS);
        rd.entry = {row_reg, step_reg[1:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= STEP_MUL0;
            row_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            row_reg   <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && command == CMD_INFLUENCE)
        begin
            last_reg <= last_influence;
        end
    end

    a_influence_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && command == CMD_INFLUENCE) |=> busy)
        else $error("influence beat did not make the block busy");

    a_write_single: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && command == CMD_WRITE) |=> !busy)
        else $error("write beat held the block busy");

    a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> $past(state_reg == ST_FINAL))
        else $error("busy fell before the final step");

endmodule

@@ rtl/core/lbs_datapath.sv @@
// Shared multiplier, wide sum, accumulators and saturating output stage.
module lbs_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cap_en,
    input  logic [lbs_pkg::WEIGHT_W-1:0]        weight,
    input  logic signed [lbs_pkg::DATA_W-1:0]   pos_x,
    input  logic signed [lbs_pkg::DATA_W-1:0]   pos_y,
    input  logic signed [lbs_pkg::DATA_W-1:0]   pos_z,
    input  lbs_pkg::uop_t                       uop,
    input  logic signed [lbs_pkg::DATA_W-1:0]   rd_data,
    output logic                                result_valid,
    output logic signed [lbs_pkg::DATA_W-1:0]   out_x,
    output logic signed [lbs_pkg::DATA_W-1:0]   out_y,
    output logic signed [lbs_pkg::DATA_W-1:0]   out_z,
    output logic                                saturated
);
    import lbs_pkg::*;

    logic [WEIGHT_W-1:0]       weight_reg;
    logic signed [DATA_W-1:0]  pos_reg [3];
    uop_t                      s1_reg;
    uop_t                      s2_reg;
    logic signed [OPND_W-1:0]  mul_a;
    logic signed [OPND_W-1:0]  mul_b;
    logic signed [DATA_W-1:0]  pos_sel;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PROD_W-1:0]  sum_reg;
    logic signed [PROD_W-1:0]  sum_next;
    logic signed [PROD_W-1:0]  trans_sum;
    logic signed [ACC_W-1:0]   t_reg;
    logic signed [ACC_W-1:0]   acc_reg [3];
    logic signed [ACC_W-1:0]   acc_row;
    logic signed [50:0]        acc_sum;
    logic                      clip_reg;
    clamp48_t                  t_clamp;
    clamp48_t                  acc_clamp;
    clamp32_t                  c_x;
    clamp32_t                  c_y;
    clamp32_t                  c_z;

    always_comb
    begin
        case (s1_reg.col)
            2'd0:    pos_sel = pos_reg[0];
            2'd1:    pos_sel = pos_reg[1];
            2'd2:    pos_sel = pos_reg[2];
            default: pos_sel = '0;
        endcase
        case (s1_reg.op)
            OP_MUL:
            begin
                mul_a = $signed({rd_data[DATA_W-1], rd_data});
                mul_b = $signed({pos_sel[DATA_W-1], pos_sel});
            end
            OP_TRANS:
            begin
                mul_a = $signed({rd_data[DATA_W-1], rd_data});
                mul_b = ONE_OPND;
            end
            OP_WLO:
            begin
                mul_a = $signed({9'b0, t_reg[23:0]});
                mul_b = $signed({16'b0, weight_reg});
            end
            OP_WHI:
            begin
                mul_a = $signed({{9{t_reg[47]}}, t_reg[47:24]});
                mul_b = $signed({16'b0, weight_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign trans_sum = sum_reg + prod_reg + ROUND_HALF;
    assign t_clamp   = clamp48({trans_sum[PROD_W-1], trans_sum[PROD_W-1:16]});
    assign acc_row   = (s2_reg.row == 2'd0) ? acc_reg[0] :
                       (s2_reg.row == 2'd1) ? acc_reg[1] : acc_reg[2];
    assign acc_sum   = {{3{acc_row[ACC_W-1]}}, acc_row}
                     + {sum_reg[PROD_W-1], sum_reg[PROD_W-1:16]};
    assign acc_clamp = clamp48(acc_sum);
    assign c_x       = clamp32(acc_reg[0]);
    assign c_y       = clamp32(acc_reg[1]);
    assign c_z       = clamp32(acc_reg[2]);

    always_comb
    begin
        case (s2_reg.op)
            OP_MUL:  sum_next = s2_reg.first ? prod_reg : sum_reg + prod_reg;
            OP_WLO:  sum_next = prod_reg + ROUND_HALF;
            OP_WHI:  sum_next = sum_reg + $signed({prod_reg[PROD_W-25:0], 24'b0});
            default: sum_next = sum_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg       <= '{op: OP_NONE, row: 2'd0, col: 2'd0, first: 1'b0};
            s2_reg       <= '{op: OP_NONE, row: 2'd0, col: 2'd0, first: 1'b0};
            acc_reg[0]   <= '0;
            acc_reg[1]   <= '0;
            acc_reg[2]   <= '0;
            clip_reg     <= 1'b0;
            result_valid <= 1'b0;
        end
        else
        begin
            s1_reg       <= uop;
            s2_reg       <= s1_reg;
            result_valid <= (s2_reg.op == OP_EMIT);
            case (s2_reg.op)
                OP_TRANS:
                begin
                    if (t_clamp.hit)
                    begin
                        clip_reg <= 1'b1;
                    end
                end
                OP_ACC:
                begin
                    if (s2_reg.row == 2'd0)
                    begin
                        acc_reg[0] <= acc_clamp.value;
                    end
                    if (s2_reg.row == 2'd1)
                    begin
                        acc_reg[1] <= acc_clamp.value;
                    end
                    if (s2_reg.row == 2'd2)
                    begin
                        acc_reg[2] <= acc_clamp.value;
                    end
                    if (acc_clamp.hit)
                    begin
                        clip_reg <= 1'b1;
                    end
                end
                OP_EMIT:
                begin
                    acc_reg[0] <= '0;
                    acc_reg[1] <= '0;
                    acc_reg[2] <= '0;
                    clip_reg   <= 1'b0;
                end
                default:
                begin
                    clip_reg <= clip_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cap_en)
        begin
            weight_reg <= (weight > ONE_Q16) ? ONE_Q16 : weight;
            pos_reg[0] <= pos_x;
            pos_reg[1] <= pos_y;
            pos_reg[2] <= pos_z;
        end
        prod_reg <= mul_a * mul_b;
        sum_reg  <= sum_next;
        if (s2_reg.op == OP_TRANS)
        begin
            t_reg <= t_clamp.value;
        end
        if (s2_reg.op == OP_EMIT)
        begin
            out_x     <= c_x.value;
            out_y     <= c_y.value;
            out_z     <= c_z.value;
            saturated <= clip_reg | c_x.hit | c_y.hit | c_z.hit;
        end
    end

    a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result beat lasted more than one cycle");

    a_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (acc_reg[0] == '0 && acc_reg[1] == '0 && acc_reg[2] == '0
                          && !clip_reg))
        else $error("accumulators not cleared with the result beat");

    a_emit_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_reg.op == OP_EMIT) |=> ##1 result_valid)
        else $error("emit step produced no result beat");

endmodule

@@ rtl/core/linear_blend_skinning_top.sv @@
// A write beat leaves busy low; an influence beat keeps busy high until its final step.
// A new influence is accepted only once the last one is through, since the single shared 33x33
// multiplier performs four matrix products and two weight products per row over three rows.
// The result beat cannot be stalled.
// Reset (rst_n low, asynchronous) clears the accumulators, the clip flag and the sequencer;
// the transform table is not cleared and holds unknown values until written.
module linear_blend_skinning_top #(
    parameter int MAX_JOINTS = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                command,
    input  logic [lbs_pkg::JOINT_W-1:0]         joint_index,
    input  logic [lbs_pkg::ENTRY_W-1:0]         entry_index,
    input  logic signed [lbs_pkg::DATA_W-1:0]   entry_value,
    input  logic [lbs_pkg::WEIGHT_W-1:0]        weight,
    input  logic signed [lbs_pkg::DATA_W-1:0]   pos_x,
    input  logic signed [lbs_pkg::DATA_W-1:0]   pos_y,
    input  logic signed [lbs_pkg::DATA_W-1:0]   pos_z,
    input  logic                                last_influence,
    output logic                                result_valid,
    output logic signed [lbs_pkg::DATA_W-1:0]   out_x,
    output logic signed [lbs_pkg::DATA_W-1:0]   out_y,
    output logic signed [lbs_pkg::DATA_W-1:0]   out_z,
    output logic                                saturated
);
    import lbs_pkg::*;

    logic                     accept;
    logic                     wr_en;
    logic                     cap_en;
    uop_t                     uop;
    rd_req_t                  rd;
    logic signed [DATA_W-1:0] rd_data;

    assign accept = start && !busy;
    assign wr_en  = accept && (command == CMD_WRITE);
    assign cap_en = accept && (command == CMD_INFLUENCE);

    lbs_seq u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .command        (command),
        .last_influence (last_influence),
        .busy           (busy),
        .uop            (uop),
        .rd             (rd)
    );

    lbs_table #(
        .MAX_JOINTS (MAX_JOINTS)
    ) u_table (
        .clk         (clk),
        .wr_en       (wr_en),
        .cap_en      (cap_en),
        .joint_index (joint_index),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .rd          (rd),
        .rd_data     (rd_data)
    );

    lbs_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cap_en       (cap_en),
        .weight       (weight),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .uop          (uop),
        .rd_data      (rd_data),
        .result_valid (result_valid),
        .out_x        (out_x),
        .out_y        (out_y),
        .out_z        (out_z),
        .saturated    (saturated)
    );

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the skinning block with directed and random beats.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lbs_pkg::*;

    localparam int JOINTS        = 64;
    localparam int ITEM_TARGET   = 1200;
    localparam int TAIL_ITEMS    = 200;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int MAX_REPORTS   = 10;

    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] Q_ONE = 32'sd65536;

    localparam logic signed [DATA_W-1:0] DIRECTED_XFORM [ENTRIES] = '{
        Q_ONE, 32'sd0, 32'sd0, 32'sd196608,
        32'sd0, Q_ONE, 32'sd0, Q_MIN,
        32'sd0, 32'sd0, Q_ONE, Q_MAX
    };

    typedef struct {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] z;
        logic                     sat;
    } skinned_pos_t;

    class skin_scoreboard;
        localparam logic signed [79:0] ACC_HI = 80'sh7FFF_FFFF_FFFF;
        localparam logic signed [79:0] ACC_LO = -ACC_HI - 80'sd1;
        localparam logic signed [79:0] Q32_HI = 80'sh7FFF_FFFF;
        localparam logic signed [79:0] Q32_LO = -Q32_HI - 80'sd1;

        logic signed [DATA_W-1:0] xform [JOINTS][ENTRIES];
        logic signed [ACC_W-1:0]  acc [3];
        bit                       clip_seen;
        skinned_pos_t             expected_q [$];
        int                       errors;

        function new();
            foreach (acc[r])
                acc[r] = '0;
            clip_seen = 1'b0;
            errors    = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function logic signed [79:0] clip48(input logic signed [79:0] v, inout bit hit);
            if (v > ACC_HI)
            begin
                hit = 1'b1;
                return ACC_HI;
            end
            if (v < ACC_LO)
            begin
                hit = 1'b1;
                return ACC_LO;
            end
            return v;
        endfunction

        function void note_beat(input logic cmd, input logic [JOINT_W-1:0] joint,
                                input logic [ENTRY_W-1:0] entry,
                                input logic signed [DATA_W-1:0] value,
                                input logic [WEIGHT_W-1:0] w,
                                input logic signed [DATA_W-1:0] px,
                                input logic signed [DATA_W-1:0] py,
                                input logic signed [DATA_W-1:0] pz,
                                input logic last);
            logic signed [79:0] p [3];
            logic signed [79:0] sum;
            logic signed [79:0] term;
            logic signed [79:0] t;
            logic signed [79:0] wt;
            logic signed [79:0] contrib;
            logic signed [79:0] v;
            logic signed [DATA_W-1:0] emitted [3];
            skinned_pos_t res;
            bit hit;
            bit sat;

            if (cmd == CMD_WRITE)
            begin
                if (entry < ENTRIES)
                    xform[joint][entry] = value;
                return;
            end

            p[0] = 80'(px);
            p[1] = 80'(py);
            p[2] = 80'(pz);
            wt   = (w > ONE_Q16) ? 80'(ONE_Q16) : 80'(w);
            hit  = 1'b0;
            for (int r = 0; r < 3; r++)
            begin
                sum = 80'(xform[joint][r * 4 + 3]);
                sum = sum <<< 16;
                for (int c = 0; c < 3; c++)
                begin
                    term = 80'(xform[joint][r * 4 + c]);
                    sum  = sum + term * p[c];
                end
                t       = clip48((sum + 80'sd32768) >>> 16, hit);
                contrib = (t * wt + 80'sd32768) >>> 16;
                v       = 80'(acc[r]);
                acc[r]  = ACC_W'(clip48(v + contrib, hit));
            end
            if (hit)
                clip_seen = 1'b1;

            if (!last)
                return;

            sat = clip_seen;
            for (int r = 0; r < 3; r++)
            begin
                v = 80'(acc[r]);
                if (v > Q32_HI)
                begin
                    v   = Q32_HI;
                    sat = 1'b1;
                end
                else if (v < Q32_LO)
                begin
                    v   = Q32_LO;
                    sat = 1'b1;
                end
                emitted[r] = v[DATA_W-1:0];
                acc[r]     = '0;
            end
            clip_seen = 1'b0;
            res.x     = emitted[0];
            res.y     = emitted[1];
            res.z     = emitted[2];
            res.sat   = sat;
            expected_q.insert(expected_q.size(), res);
        endfunction

        function void check_result(input logic signed [DATA_W-1:0] x,
                                   input logic signed [DATA_W-1:0] y,
                                   input logic signed [DATA_W-1:0] z,
                                   input logic sat);
            skinned_pos_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("Unexpected result beat: x=%0d y=%0d z=%0d sat=%0b", x, y, z, sat);
                return;
            end
            want = expected_q.pop_front();
            if (want.x !== x || want.y !== y || want.z !== z || want.sat !== sat)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("Mismatch: expected x=%0d y=%0d z=%0d sat=%0b,",
                             want.x, want.y, want.z, want.sat,
                             " got x=%0d y=%0d z=%0d sat=%0b", x, y, z, sat);
            end
        endfunction
    endclass

    logic                       clk            = 1'b0;
    logic                       rst_n          = 1'b0;
    logic                       start          = 1'b0;
    logic                       busy;
    logic                       command        = CMD_WRITE;
    logic [JOINT_W-1:0]         joint_index    = '0;
    logic [ENTRY_W-1:0]         entry_index    = '0;
    logic signed [DATA_W-1:0]   entry_value    = '0;
    logic [WEIGHT_W-1:0]        weight         = '0;
    logic signed [DATA_W-1:0]   pos_x          = '0;
    logic signed [DATA_W-1:0]   pos_y          = '0;
    logic signed [DATA_W-1:0]   pos_z          = '0;
    logic                       last_influence = 1'b0;
    logic                       result_valid;
    logic signed [DATA_W-1:0]   out_x;
    logic signed [DATA_W-1:0]   out_y;
    logic signed [DATA_W-1:0]   out_z;
    logic                       saturated;

    int  cycle_count = 0;
    int  beats_sent  = 0;
    bit  idling_on   = 1'b1;

    skin_scoreboard sb = new();

    linear_blend_skinning_top #(.MAX_JOINTS(JOINTS)) dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count == CYCLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid === 1'b1)
                sb.check_result(out_x, out_y, out_z, saturated);
            if (start && busy === 1'b0)
                sb.note_beat(command, joint_index, entry_index, entry_value, weight,
                             pos_x, pos_y, pos_z, last_influence);
        end
    end

    task automatic send_beat(input logic cmd, input logic [JOINT_W-1:0] joint,
                             input logic [ENTRY_W-1:0] entry,
                             input logic signed [DATA_W-1:0] value,
                             input logic [WEIGHT_W-1:0] w,
                             input logic signed [DATA_W-1:0] px,
                             input logic signed [DATA_W-1:0] py,
                             input logic signed [DATA_W-1:0] pz,
                             input logic last);
        start          <= 1'b1;
        command        <= cmd;
        joint_index    <= joint;
        entry_index    <= entry;
        entry_value    <= value;
        weight         <= w;
        pos_x          <= px;
        pos_y          <= py;
        pos_z          <= pz;
        last_influence <= last;
        beats_sent++;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    task automatic write_entry(input logic [JOINT_W-1:0] joint, input logic [ENTRY_W-1:0] entry,
                               input logic signed [DATA_W-1:0] value);
        send_beat(CMD_WRITE, joint, entry, value, WEIGHT_W'($urandom), $urandom, $urandom,
                  $urandom, 1'($urandom));
    endtask

    task automatic influence(input logic [JOINT_W-1:0] joint, input logic [WEIGHT_W-1:0] w,
                             input logic signed [DATA_W-1:0] px,
                             input logic signed [DATA_W-1:0] py,
                             input logic signed [DATA_W-1:0] pz,
                             input logic last);
        send_beat(CMD_INFLUENCE, joint, ENTRY_W'($urandom), $urandom, w, px, py, pz, last);
    endtask

    task automatic gap();
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    function automatic logic signed [DATA_W-1:0] rail();
        return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_extreme();
        case ($urandom_range(0, 4))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return 32'sd0;
            3: return -32'sd1;
            default: return 32'sd1;
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_coeff();
        case ($urandom_range(0, 9))
            0, 1: return $urandom;
            2: return pick_extreme();
            default: return $signed($urandom_range(0, 262144)) - 131072;
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_pos();
        case ($urandom_range(0, 9))
            0, 1: return $urandom;
            2: return pick_extreme();
            default: return $signed($urandom_range(0, 13107200)) - 6553600;
        endcase
    endfunction

    function automatic logic [WEIGHT_W-1:0] rand_weight();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return ONE_Q16;
            2: return WEIGHT_W'($urandom_range(65537, 131071));
            default: return WEIGHT_W'($urandom_range(0, 65536));
        endcase
    endfunction

    initial
    begin
        int  pool [$];
        int  n;
        int  j;
        bit  stress;
        bit  drained_mid;

        drained_mid = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < ENTRIES; k++)
            write_entry(6'd0, ENTRY_W'(k), DIRECTED_XFORM[k]);
        write_entry(6'd0, 4'd15, -32'sd1);
        write_entry(6'd63, 4'd12, Q_MIN);
        influence(6'd0, ONE_Q16, 32'sd65536, 32'sd131072, -32'sd65536, 1'b1);
        influence(6'd0, '0, Q_MAX, Q_MIN, Q_MAX, 1'b1);
        influence(6'd0, 17'd131071, Q_MAX, Q_MIN, Q_MAX, 1'b1);
        influence(6'd0, 17'd21845, 32'sd65536, 32'sd65536, 32'sd65536, 1'b0);
        influence(6'd0, 17'd21845, -32'sd65536, 32'sd32768, 32'sd7, 1'b0);
        influence(6'd0, 17'd21846, 32'sd12345, -32'sd98765, 32'sd0, 1'b1);
        influence(6'd0, 17'd32768, 32'sd1, -32'sd1, 32'sd0, 1'b1);
        influence(6'd0, 17'd65535, -32'sd1, -32'sd3, 32'sd5, 1'b1);
        drain();

        // Joint 63 holds only rail values so that the stress vertices drive the clamps.
        j = 0;
        pool.insert(pool.size(), j);
        for (int i = 1; i <= 7; i++)
        begin
            j = (i == 7) ? 62 : i;
            for (int k = 0; k < ENTRIES; k++)
            begin
                write_entry(JOINT_W'(j), ENTRY_W'(k), rand_coeff());
                gap();
            end
            pool.insert(pool.size(), j);
        end
        for (int k = 0; k < ENTRIES; k++)
            write_entry(6'd63, ENTRY_W'(k), rail());

        while (beats_sent < ITEM_TARGET)
        begin
            idling_on = (beats_sent < ITEM_TARGET - TAIL_ITEMS) && ((beats_sent / 100) % 3 != 2);
            if (!drained_mid && beats_sent >= ITEM_TARGET / 2)
            begin
                drain();
                drained_mid = 1'b1;
            end
            if ($urandom_range(0, 6) == 0)
            begin
                j = $urandom_range(0, 63);
                write_entry(JOINT_W'(j), ENTRY_W'($urandom_range(0, 15)),
                            (j == 63) ? rail() : rand_coeff());
                gap();
            end
            else
            begin
                stress = ($urandom_range(0, 9) == 0);
                n = stress ? $urandom_range(2, 4) : $urandom_range(1, 4);
                for (int k = 1; k <= n; k++)
                begin
                    if (stress)
                        influence(6'd63, ONE_Q16, rail(), rail(), rail(), k == n);
                    else
                        influence(JOINT_W'(pool[$urandom_range(0, pool.size() - 1)]),
                                  rand_weight(), rand_pos(), rand_pos(), rand_pos(), k == n);
                    gap();
                end
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
